// File: rtl/mbep_pkg.sv
// Shared types and constants of the masked bit extract packer.
// No dependencies; every other file of the block imports it.
package mbep_pkg;

	localparam int WORD_W  = 64;
	localparam int CNT_W   = 7;
	localparam int PCNT_W  = 6;
	localparam int TOTAL_W = 32;
	localparam int ADDR_W  = 3;

	localparam logic [ADDR_W-1:0] REG_EXCLUDE = 3'd0;

	localparam logic [CNT_W-1:0]   FULL_BITS = 7'd64;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [WORD_W-1:0]  packed_word;
		logic [CNT_W-1:0]   word_bits;
		logic               final_res;
		logic [TOTAL_W-1:0] total_bits;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} res_pair_t;

endpackage

// File: rtl/mbep_extract.sv
// Parallel bit extract: gathers the data bits under the mask, lowest first.
// Uses a log-depth prefix count of the mask. Depends on mbep_pkg.
module mbep_extract import mbep_pkg::*; (
	input  logic [WORD_W-1:0] data_word,
	input  logic [WORD_W-1:0] sel_mask,
	output logic [WORD_W-1:0] extracted,
	output logic [CNT_W-1:0]  bit_cnt
);

	logic [CNT_W-1:0] lvl [0:6][0:WORD_W-1];

	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			lvl[0][i] = {{(CNT_W-1){1'b0}}, sel_mask[i]};
		end
		for (int d = 0; d < 6; d++) begin
			for (int i = 0; i < WORD_W; i++) begin
				if (i >= (1 << d)) begin
					lvl[d+1][i] = lvl[d][i] + lvl[d][i - (1 << d)];
				end else begin
					lvl[d+1][i] = lvl[d][i];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			extracted[k] = 1'b0;
			for (int i = 0; i < WORD_W; i++) begin
				if (sel_mask[i] && data_word[i] && lvl[6][i] == CNT_W'(k + 1)) begin
					extracted[k] = 1'b1;
				end
			end
		end
	end

	assign bit_cnt = lvl[6][WORD_W-1];

endmodule

// File: rtl/mbep_merge.sv
// Pending-bit accumulator: merges extracted bits, builds full and final words.
// Holds the pending bits, their count and the saturating total. Depends on mbep_pkg.
module mbep_merge import mbep_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [WORD_W-1:0] extracted,
	input  logic [CNT_W-1:0]  bit_cnt,
	input  logic              last,
	output res_pair_t         results
);

	logic [WORD_W-1:0]  pending_bits_q;
	logic [PCNT_W-1:0]  pending_count_q;
	logic [TOTAL_W-1:0] bit_total_q;

	logic [WORD_W-1:0]  merged;
	logic [WORD_W-1:0]  spill;
	logic [WORD_W-1:0]  next_bits;
	logic [CNT_W-1:0]   sum;
	logic [PCNT_W-1:0]  next_count;
	logic               full;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] next_total;
	res_t               full_res;
	res_t               tail_res;

	always_comb begin
		merged     = pending_bits_q | (extracted << pending_count_q);
		spill      = (extracted >> 1) >> (~pending_count_q);
		sum        = CNT_W'(pending_count_q) + bit_cnt;
		full       = sum[CNT_W-1];
		next_count = sum[PCNT_W-1:0];
		next_bits  = full ? spill : merged;
		total_sum  = {1'b0, bit_total_q} + (TOTAL_W+1)'(bit_cnt);
		next_total = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

		full_res.packed_word = merged;
		full_res.word_bits   = FULL_BITS;
		full_res.final_res   = last && (next_count == '0);
		full_res.total_bits  = next_total;

		tail_res.packed_word = next_bits;
		tail_res.word_bits   = {1'b0, next_count};
		tail_res.final_res   = 1'b1;
		tail_res.total_bits  = next_total;

		results.v0 = full || last;
		results.v1 = full && last && (next_count != '0);
		results.r0 = full ? full_res : tail_res;
		results.r1 = tail_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_bits_q  <= '0;
			pending_count_q <= '0;
			bit_total_q     <= '0;
		end else if (advance) begin
			if (last) begin
				pending_bits_q  <= '0;
				pending_count_q <= '0;
				bit_total_q     <= '0;
			end else begin
				pending_bits_q  <= next_bits;
				pending_count_q <= next_count;
				bit_total_q     <= next_total;
			end
		end
	end

endmodule

// File: rtl/mbep_outbuf.sv
// Two-slot result buffer: the head slot drives the output port, the second
// slot holds the final word when one item yields two results. Depends on mbep_pkg.
module mbep_outbuf import mbep_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_pair_t results,
	output logic      ready,
	output logic      out_valid,
	input  logic      out_stall,
	output res_t      head
);

	logic a_v_q;
	logic b_v_q;
	res_t a_q;
	res_t b_q;
	logic take;

	assign take      = a_v_q && !out_stall;
	assign ready     = !b_v_q && (!a_v_q || take);
	assign out_valid = a_v_q;
	assign head      = a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else if (b_v_q) begin
			if (take) begin
				b_v_q <= 1'b0;
			end
		end else if (push) begin
			a_v_q <= results.v0;
			b_v_q <= results.v1;
		end else if (take) begin
			a_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (b_v_q) begin
			if (take) begin
				a_q <= b_q;
			end
		end else if (push) begin
			a_q <= results.r0;
			b_q <= results.r1;
		end
	end

endmodule

// File: rtl/masked_bit_extract_packer.sv
// Masked bit extract packer: input register, extract stage, merge and result buffer.
// Depends on mbep_pkg, mbep_extract, mbep_merge and mbep_outbuf.
//
// Usage:
//   Input channel (in_valid / in_stall) carries data_word, mask_word and last.
//   The data bits under the mask (under its inverse when exclude is set) are
//   packed densely, lowest first. Each 64 packed bits leave as one result
//   (word_bits 64). On last, the partial word follows with final_res high;
//   if no bits are left over, the full word itself carries final_res.
//   total_bits gives the saturating bit count of the vector on every result.
//   Output channel (out_valid / out_stall) carries one result per transfer.
//   Items pass the input and extract stage registers, then the result buffer.
//   Throughput: one item per cycle while out_stall is low; an item that yields two
//   results holds the merge stage until the first leaves the single output port.
//   Output stall holds the result buffer and backs up through both stages
//   to in_stall; two items stay buffered while a result waits. Reset clears all
//   stages, the pending bits, the count and exclude. exclude is written over the
//   APB port at address 0; the user must do so only while idle (unenforced).
module masked_bit_extract_packer import mbep_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [WORD_W-1:0]  data_word,
	input  logic [WORD_W-1:0]  mask_word,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [WORD_W-1:0]  packed_word,
	output logic [CNT_W-1:0]   word_bits,
	output logic               final_res,
	output logic [TOTAL_W-1:0] total_bits
);

	logic exclude_q;

	logic              s1_v;
	logic [WORD_W-1:0] data_s1;
	logic [WORD_W-1:0] mask_s1;
	logic              last_s1;

	logic              s2_v;
	logic [WORD_W-1:0] bits_s2;
	logic [CNT_W-1:0]  cnt_s2;
	logic              last_s2;

	logic [WORD_W-1:0] sel_mask;
	logic [WORD_W-1:0] extracted;
	logic [CNT_W-1:0]  bit_cnt;
	res_pair_t         results;
	res_t              head;
	logic              buf_ready;
	logic              s2_adv;
	logic              s2_free;
	logic              s1_free;
	logic              in_take;

	assign pready = 1'b1;
	assign prdata = {31'b0, exclude_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exclude_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_EXCLUDE[ADDR_W-1:2]) begin
			exclude_q <= pwdata[0];
		end
	end

	assign s2_adv   = s2_v && buf_ready;
	assign s2_free  = !s2_v || buf_ready;
	assign s1_free  = !s1_v || s2_free;
	assign in_stall = !s1_free;
	assign in_take  = in_valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v <= in_valid;
			end
			if (s2_free) begin
				s2_v <= s1_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_word;
			mask_s1 <= mask_word;
			last_s1 <= last;
		end
		if (s2_free && s1_v) begin
			bits_s2 <= extracted;
			cnt_s2  <= bit_cnt;
			last_s2 <= last_s1;
		end
	end

	assign sel_mask = exclude_q ? ~mask_s1 : mask_s1;

	mbep_extract u_extract (
		.data_word (data_s1),
		.sel_mask  (sel_mask),
		.extracted (extracted),
		.bit_cnt   (bit_cnt)
	);

	mbep_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (s2_adv),
		.extracted (bits_s2),
		.bit_cnt   (cnt_s2),
		.last      (last_s2),
		.results   (results)
	);

	mbep_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s2_adv),
		.results   (results),
		.ready     (buf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign packed_word = head.packed_word;
	assign word_bits   = head.word_bits;
	assign final_res   = head.final_res;
	assign total_bits  = head.total_bits;

endmodule

// File: test/tb_masked_bit_extract_packer.sv
`timescale 1ns / 100ps
// Testbench for masked_bit_extract_packer: directed table, then random word-pair vectors.
// Checks every result transfer against an in-bench packing predictor; depends on mbep_pkg.

module tb_masked_bit_extract_packer import mbep_pkg::*;;

	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam int N_DIR = 19;
	localparam int N_PHASES = 4;
	localparam int PHASE_ITEMS = 265;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int CALM_AFTER = 900;

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [WORD_W-1:0] mask;
		logic              fin;
		logic              excl;
		logic              typed;
		res_t              want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [WORD_W-1:0]  data_word;
	logic [WORD_W-1:0]  mask_word;
	logic               last;
	logic               out_valid;
	logic               out_stall;
	logic [WORD_W-1:0]  packed_word;
	logic [CNT_W-1:0]   word_bits;
	logic               final_res;
	logic [TOTAL_W-1:0] total_bits;

	logic               excl_now = 1'b0;
	logic [WORD_W-1:0]  acc_bits = '0;
	int                 acc_cnt = 0;
	logic [TOTAL_W-1:0] vec_total = '0;
	res_t               owed_words[$];
	int                 errs = 0;
	int                 n_sent = 0;
	logic               calm = 1'b0;
	logic               quiet = 1'b0;
	logic               long_hold = 1'b0;
	dir_row_t           dir_rows[N_DIR];

	masked_bit_extract_packer u_dut (.*);

	always #6 clk = ~clk;

	task automatic pack_pair(input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] m,
		input logic fin);
		logic [WORD_W-1:0]  sel;
		logic [WORD_W-1:0]  y;
		logic [WORD_W-1:0]  merged;
		logic [TOTAL_W:0]   sum;
		int                 cnt;
		int                 pc;
		logic               full;
		logic               closed;
		res_t               full_w;
		res_t               tail_w;
		sel = excl_now ? ~m : m;
		y = '0;
		cnt = 0;
		for (int i = 0; i < WORD_W; i++) begin
			if (sel[i]) begin
				y[cnt] = d[i];
				cnt++;
			end
		end
		pc = acc_cnt;
		merged = acc_bits | (y << pc);
		sum = {1'b0, vec_total} + cnt;
		vec_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		full = (pc + cnt >= WORD_W);
		if (full) begin
			acc_bits = (pc == 0) ? '0 : (y >> (WORD_W - pc));
			acc_cnt = pc + cnt - WORD_W;
		end else begin
			acc_bits = merged;
			acc_cnt = pc + cnt;
		end
		closed = full && (acc_cnt == 0);
		full_w.packed_word = merged;
		full_w.word_bits = FULL_BITS;
		full_w.final_res = fin && closed;
		full_w.total_bits = vec_total;
		if (full)
			owed_words.push_back(full_w);
		if (fin && !closed) begin
			tail_w.packed_word = acc_bits;
			tail_w.word_bits = CNT_W'(acc_cnt);
			tail_w.final_res = 1'b1;
			tail_w.total_bits = vec_total;
			owed_words.push_back(tail_w);
		end
		if (fin) begin
			acc_bits = '0;
			acc_cnt = 0;
			vec_total = '0;
		end
	endtask

	function automatic int pick_gap();
		if (calm || long_hold || quiet)
			return 0;
		if ($urandom_range(0, 4) != 0)
			return 0;
		return $urandom_range(1, 11);
	endfunction

	function automatic logic [WORD_W-1:0] rand_data();
		int k;
		k = $urandom_range(0, 15);
		if (k == 0)
			return '0;
		if (k == 1)
			return ALL_ONES;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [WORD_W-1:0] rand_mask();
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		int                lo;
		int                hi;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		lo = $urandom_range(0, WORD_W - 1);
		hi = $urandom_range(lo, WORD_W - 1);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			3: return a & b;
			4: return a | b;
			5: return 64'h1 << lo;
			6: return (ALL_ONES << lo) & (ALL_ONES >> (WORD_W - 1 - hi));
			default: return a;
		endcase
	endfunction

	task automatic send_pair(input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] m,
		input logic fin, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= d;
		mask_word <= m;
		last <= fin;
		do @(posedge clk); while (in_stall);
		pack_pair(d, m, fin);
		n_sent++;
	endtask

	task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] a, input logic [31:0] wd,
		output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_exclude_reg();
		logic [31:0] rd;
		apb_xfer(1'b0, REG_EXCLUDE, 32'd0, rd);
		if (rd !== {31'd0, excl_now}) begin
			$error("prdata: expected %h, got %h", {31'd0, excl_now}, rd);
			errs++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (owed_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_exclude(input logic v);
		logic [31:0] rd;
		wait_drained();
		apb_xfer(1'b1, REG_EXCLUDE, {31'd0, v}, rd);
		excl_now = v;
		check_exclude_reg();
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_words.size() == 0) begin
				$error("unexpected result transfer: packed_word %h", packed_word);
				errs++;
			end else begin
				want = owed_words.pop_front();
				if (packed_word !== want.packed_word) begin
					$error("packed_word: expected %h, got %h", want.packed_word, packed_word);
					errs++;
				end
				if (word_bits !== want.word_bits) begin
					$error("word_bits: expected %0d, got %0d", want.word_bits, word_bits);
					errs++;
				end
				if (final_res !== want.final_res) begin
					$error("final_res: expected %b, got %b", want.final_res, final_res);
					errs++;
				end
				if (total_bits !== want.total_bits) begin
					$error("total_bits: expected %0d, got %0d", want.total_bits, total_bits);
					errs++;
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int          vlen;
		int          ph_n;
		logic        ph_excl;
		logic [31:0] rd;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_word = '0;
		mask_word = '0;
		last = 1'b0;

		dir_rows[0]  = '{ALL_ONES, 64'h0, 1'b1, 1'b0, 1'b1, '{64'h0, 7'd0, 1'b1, 32'd0}};
		dir_rows[1]  = '{ALL_ONES, ALL_ONES, 1'b1, 1'b0, 1'b1,
			'{ALL_ONES, FULL_BITS, 1'b1, 32'd64}};
		dir_rows[2]  = '{64'h0, ALL_ONES, 1'b1, 1'b0, 1'b1, '{64'h0, FULL_BITS, 1'b1, 32'd64}};
		dir_rows[3]  = '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, '0};
		dir_rows[4]  = '{ALL_ONES, ALL_ONES, 1'b1, 1'b0, 1'b0, '0};
		dir_rows[5]  = '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 1'b0, '0};
		dir_rows[6]  = '{64'h0123_4567_89AB_CDEF, ALL_ONES, 1'b0, 1'b0, 1'b0, '0};
		dir_rows[7]  = '{64'hDEAD_BEEF_CAFE_F00D, 64'h0, 1'b1, 1'b0, 1'b0, '0};
		dir_rows[8]  = '{64'h1, 64'h1, 1'b0, 1'b0, 1'b0, '0};
		dir_rows[9]  = '{ALL_ONES, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, '0};
		dir_rows[10] = '{64'h0, 64'h0, 1'b1, 1'b0, 1'b1, '{64'h0, 7'd0, 1'b1, 32'd64}};
		dir_rows[11] = '{64'hA, 64'hF, 1'b0, 1'b0, 1'b0, '0};
		dir_rows[12] = '{ALL_ONES, 64'h0FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, '0};
		dir_rows[13] = '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b1,
			'{64'h1, 7'd1, 1'b1, 32'd1}};
		dir_rows[14] = '{ALL_ONES, 64'h0, 1'b1, 1'b1, 1'b1, '{ALL_ONES, FULL_BITS, 1'b1, 32'd64}};
		dir_rows[15] = '{ALL_ONES, ALL_ONES, 1'b1, 1'b1, 1'b1, '{64'h0, 7'd0, 1'b1, 32'd0}};
		dir_rows[16] = '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b1,
			'{64'h0, 7'd32, 1'b1, 32'd32}};
		dir_rows[17] = '{64'hFFFF_0000_FFFF_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b1, 1'b0, '0};
		dir_rows[18] = '{64'hC3A5_0F1E_7788_9911, 64'hF0F0_0FF0_1234_8001, 1'b1, 1'b1, 1'b0, '0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		check_exclude_reg();

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].excl != excl_now)
				set_exclude(dir_rows[i].excl);
			send_pair(dir_rows[i].data, dir_rows[i].mask, dir_rows[i].fin, pick_gap());
			if (dir_rows[i].typed)
				owed_words[owed_words.size() - 1] = dir_rows[i].want;
		end

		for (int p = 0; p < N_PHASES; p++) begin
			ph_excl = (p == 1 || p == 2);
			set_exclude(ph_excl);
			if (p == 2) begin
				apb_xfer(1'b1, SPARE_ADDR, 32'hFFFF_FFFF, rd);
				check_exclude_reg();
			end
			ph_n = 0;
			while (ph_n < PHASE_ITEMS) begin
				vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
				quiet = ($urandom_range(0, 3) == 0);
				for (int j = 0; j < vlen; j++) begin
					if (p == 1 && ph_n == 100)
						long_hold = 1'b1;
					send_pair(rand_data(), rand_mask(), j == vlen - 1, pick_gap());
					ph_n++;
					if (n_sent >= CALM_AFTER)
						calm = 1'b1;
				end
			end
		end

		wait_drained();
		if (errs == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
